// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the console engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

   localparam int MODE_W      = 3;
   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = 11;
   localparam int POS_W       = 11;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR     = 8'h0A;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR       = 8'h20;
   localparam logic [CELL_W-1:0]  RESET_CELL       = 16'h0F20;
   localparam logic [COLOR_W-1:0] RESET_BACKGROUND = 4'h0;
   localparam logic [COLOR_W-1:0] RESET_FOREGROUND = 4'hF;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT       = 3'd0,
      MODE_HEX       = 3'd1,
      MODE_BACKSPACE = 3'd2,
      MODE_CLEAR     = 3'd3,
      MODE_RECOLOR   = 3'd4,
      MODE_READ      = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BACKGROUND = 2'd0,
      CSR_FOREGROUND = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      WALK_FROM_ZERO       = 2'd0,
      WALK_FROM_SECOND_ROW = 2'd1,
      WALK_FROM_LAST_ROW   = 2'd2
   } walk_start_type;

   typedef struct packed {
      logic           load_item;
      logic           exec;
      logic           copy_rd;
      logic           fill_wr;
      logic           fill_init;
      logic           walk_load;
      walk_start_type walk_start;
      logic           walk_step;
      logic           capture_rd;
      logic           load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scroll;
      logic recolor;
      logic clear;
      logic read_ok;
      logic walk_last;
      logic rsp_free;
   } sts_type;

endpackage

// ----- hw/rtl/text_console_writer_core.sv -----
// Text-mode console engine: a COLUMNS x ROWS screen of 16-bit cells (attribute in the high
// byte, character in the low byte) held in one single-port-write, registered-read RAM, plus a
// cursor. Each request word runs one command (put char, hex digit, backspace, clear, recolor,
// read cell) and returns one response word with the linear cursor position and, for reads,
// the cell contents. Put char, newline, hex digit, backspace, out-of-range reads and unused
// modes execute against the RAM in ST_EXEC and then load the response register in ST_DONE,
// which also accepts the next request once that register is free. A read of a cell on the
// screen adds ST_READ between the two to take the RAM's registered read data. A put that
// scrolls, recolor and clear each walk the RAM one cell per cycle through its one write port
// (scroll and recolor read one cell ahead) before the response is loaded.
// After reset the engine fills the screen with 0x0F20 with req_stall high; color register
// writes are taken at any time. The response register lets a new request be accepted while
// the previous response is still stalled.
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::MODE_W-1:0]       req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]       req_read_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]        rsp_cursor_pos,
   output logic [tcw_pkg::CELL_W-1:0]       rsp_read_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]      csr_wdata
);

   tcw_pkg::cmd_type cmd;
   tcw_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_char_code    (req_char_code),
      .req_read_address (req_read_address),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

// ----- hw/rtl/tcw_ram.sv -----
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
`include "assert_macros.svh"

module tcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output tcw_pkg::cmd_type cmd,
   input  tcw_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_EXEC  = 8'b0000_0100,
      ST_COPY  = 8'b0000_1000,
      ST_DRAIN = 8'b0001_0000,
      ST_FILL  = 8'b0010_0000,
      ST_READ  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept_ok;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      accept_ok = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_wr   = 1'b1;
            cmd.fill_init = 1'b1;
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            accept_ok = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.scroll) begin
               cmd.walk_load  = 1'b1;
               cmd.walk_start = tcw_pkg::WALK_FROM_SECOND_ROW;
               state_in       = ST_COPY;
            end else if (sts.recolor) begin
               cmd.walk_load  = 1'b1;
               cmd.walk_start = tcw_pkg::WALK_FROM_ZERO;
               state_in       = ST_COPY;
            end else if (sts.clear) begin
               cmd.walk_load  = 1'b1;
               cmd.walk_start = tcw_pkg::WALK_FROM_ZERO;
               state_in       = ST_FILL;
            end else if (sts.read_ok) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy_rd   = 1'b1;
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.recolor) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk_load  = 1'b1;
               cmd.walk_start = tcw_pkg::WALK_FROM_LAST_ROW;
               state_in       = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_wr   = 1'b1;
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.capture_rd = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               accept_ok    = 1'b1;
               state_in     = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      cmd.load_item = accept_ok & req_valid;
   end

   assign req_stall = ~accept_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_to_exec, clock, reset, cmd.load_item, state_ff == ST_EXEC,
      "accepted word did not enter execution")
   `ASSERT_IMPLY(a_drain_after_copy, clock, reset, state_ff == ST_DRAIN,
      $past(state_ff) == ST_COPY, "drain cycle without a preceding copy walk")

endmodule

// ----- hw/rtl/tcw_datapath.sv -----
`include "assert_macros.svh"

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::cmd_type                  cmd,
   output tcw_pkg::sts_type                  sts,
   input  logic [tcw_pkg::MODE_W-1:0]        req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]        req_read_address,
   input  logic                              csr_write,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]       csr_wdata,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [tcw_pkg::POS_W-1:0]         rsp_cursor_pos,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_read_data
);

   localparam int CellCount = COLUMNS * ROWS;
   localparam int AddrW     = $clog2(CellCount);
   localparam int ColW      = $clog2(COLUMNS);
   localparam int RowW      = $clog2(ROWS);

   function automatic logic [tcw_pkg::CHAR_W-1:0] hex_char(input logic [3:0] d);
      logic [tcw_pkg::CHAR_W-1:0] dx;
      dx = {4'h0, d};
      return (d < 4'd10) ? (8'h30 + dx) : (8'h37 + dx);
   endfunction

   logic [tcw_pkg::MODE_W-1:0]  mode_ff;
   logic [tcw_pkg::CHAR_W-1:0]  char_ff;
   logic [tcw_pkg::ADDR_W-1:0]  addr_ff;
   logic [ColW-1:0]             col_ff, col_in;
   logic [RowW-1:0]             row_ff, row_in;
   logic [tcw_pkg::COLOR_W-1:0] bg_ff, fg_ff;
   logic [7:0]                  attr;
   logic [AddrW-1:0]            walk_ff, walk_in;
   logic [AddrW-1:0]            dst_ff, dst_in;
   logic [AddrW-1:0]            copy_offset;
   logic                        pend_ff;
   logic [tcw_pkg::CELL_W-1:0]  rdata_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]   rsp_pos_ff;
   logic [tcw_pkg::CELL_W-1:0]  rsp_data_ff;

   logic                        is_put, newline, col_last, row_last, row_adv;
   logic [tcw_pkg::CHAR_W-1:0]  put_ch;
   logic [ColW-1:0]             bs_col, sel_col;
   logic [RowW-1:0]             bs_row, sel_row;
   logic [AddrW-1:0]            cell_idx, pos_idx;
   logic                        exec_wr;

   logic                        wr_en;
   logic [AddrW-1:0]            wr_addr, rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  wr_data, rd_data;

   assign attr     = {bg_ff, fg_ff};
   assign is_put   = (mode_ff inside {tcw_pkg::MODE_PUT, tcw_pkg::MODE_HEX});
   assign newline  = (mode_ff == tcw_pkg::MODE_PUT) && (char_ff == tcw_pkg::NEWLINE_CHAR);
   assign put_ch   = (mode_ff == tcw_pkg::MODE_HEX) ? hex_char(char_ff[3:0]) : char_ff;
   assign col_last = (col_ff == ColW'(COLUMNS - 1));
   assign row_last = (row_ff == RowW'(ROWS - 1));
   assign row_adv  = is_put && (newline || col_last);

   always_comb begin
      bs_col = col_ff;
      bs_row = row_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - ColW'(1);
      end else if (row_ff != '0) begin
         bs_row = row_ff - RowW'(1);
         bs_col = ColW'(COLUMNS - 1);
      end
   end

   assign sel_col  = (mode_ff == tcw_pkg::MODE_BACKSPACE) ? bs_col : col_ff;
   assign sel_row  = (mode_ff == tcw_pkg::MODE_BACKSPACE) ? bs_row : row_ff;
   assign cell_idx = AddrW'(sel_row * COLUMNS) + AddrW'(sel_col);
   assign pos_idx  = AddrW'(row_ff * COLUMNS) + AddrW'(col_ff);

   // cursor update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.exec) begin
         case (mode_ff)
            tcw_pkg::MODE_PUT, tcw_pkg::MODE_HEX: begin
               if (row_adv) begin
                  col_in = '0;
                  if (!row_last) begin
                     row_in = row_ff + RowW'(1);
                  end
               end else begin
                  col_in = col_ff + ColW'(1);
               end
            end
            tcw_pkg::MODE_BACKSPACE: begin
               col_in = bs_col;
               row_in = bs_row;
            end
            tcw_pkg::MODE_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign exec_wr = cmd.exec &&
                    ((is_put && !newline) || (mode_ff == tcw_pkg::MODE_BACKSPACE));

   // walk counter and copy pipeline
   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_load) begin
         case (cmd.walk_start)
            tcw_pkg::WALK_FROM_ZERO:       walk_in = '0;
            tcw_pkg::WALK_FROM_SECOND_ROW: walk_in = AddrW'(COLUMNS);
            tcw_pkg::WALK_FROM_LAST_ROW:   walk_in = AddrW'(CellCount - COLUMNS);
            default:                       walk_in = '0;
         endcase
      end else if (cmd.walk_step) begin
         walk_in = walk_ff + AddrW'(1);
      end
   end

   assign copy_offset = (mode_ff == tcw_pkg::MODE_RECOLOR) ? '0 : AddrW'(COLUMNS);
   assign dst_in      = walk_ff - copy_offset;

   // single write port: copy write, then fill, then the item's own cell
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cell_idx;
      wr_data = {attr, put_ch};
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = (mode_ff == tcw_pkg::MODE_RECOLOR) ? {attr, rd_data[7:0]} : rd_data;
      end else if (cmd.fill_wr) begin
         wr_en   = 1'b1;
         wr_addr = walk_ff;
         wr_data = cmd.fill_init ? tcw_pkg::RESET_CELL : {attr, tcw_pkg::BLANK_CHAR};
      end else if (exec_wr) begin
         wr_en   = 1'b1;
         wr_addr = cell_idx;
         wr_data = (mode_ff == tcw_pkg::MODE_BACKSPACE) ?
                   {attr, tcw_pkg::BLANK_CHAR} : {attr, put_ch};
      end
   end

   assign rd_addr = cmd.copy_rd ? walk_ff : AddrW'(addr_ff);

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CellCount)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.scroll    = row_adv && row_last;
   assign sts.recolor   = (mode_ff == tcw_pkg::MODE_RECOLOR);
   assign sts.clear     = (mode_ff == tcw_pkg::MODE_CLEAR);
   assign sts.read_ok   = (mode_ff == tcw_pkg::MODE_READ) && (32'(addr_ff) < CellCount);
   assign sts.walk_last = (walk_ff == AddrW'(CellCount - 1));
   assign sts.rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         bg_ff        <= tcw_pkg::RESET_BACKGROUND;
         fg_ff        <= tcw_pkg::RESET_FOREGROUND;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         walk_ff      <= walk_in;
         pend_ff      <= cmd.copy_rd;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == tcw_pkg::CSR_BACKGROUND)) begin
            bg_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == tcw_pkg::CSR_FOREGROUND)) begin
            fg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      if (cmd.load_item) begin
         mode_ff <= req_mode;
         char_ff <= req_char_code;
         addr_ff <= req_read_address;
      end
      if (cmd.load_item) begin
         rdata_ff <= '0;
      end else if (cmd.capture_rd) begin
         rdata_ff <= rd_data;
      end
      if (cmd.load_rsp) begin
         rsp_pos_ff  <= tcw_pkg::POS_W'(pos_idx);
         rsp_data_ff <= rdata_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_read_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_cursor_in_range, clock, reset,
      (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS), "cursor left the screen")
   `ASSERT_IMPLY(a_write_port_free, clock, reset, pend_ff,
      !cmd.fill_wr && !cmd.exec, "copy write collides with another cell write")
   `ASSERT_NEXT(a_rsp_loaded, clock, reset, cmd.load_rsp, rsp_valid_ff,
      "result register not valid after load")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int SCREEN_COLS   = 80;
   localparam int SCREEN_ROWS   = 25;
   localparam int SCREEN_CELLS  = SCREEN_COLS * SCREEN_ROWS;
   localparam int IDLE_LIMIT    = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 175;

   localparam logic [tcw_pkg::MODE_W-1:0]      MODE_SPARE_LO = 3'd6;
   localparam logic [tcw_pkg::MODE_W-1:0]      MODE_SPARE_HI = 3'd7;
   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;
   localparam logic [tcw_pkg::CHAR_W-1:0]      DIGIT_ZERO    = 8'h30;
   localparam logic [tcw_pkg::CHAR_W-1:0]      LETTER_A      = 8'h41;

   typedef struct packed {
      logic [tcw_pkg::POS_W-1:0]  cursor_pos;
      logic [tcw_pkg::CELL_W-1:0] read_data;
   } console_reply_type;

   class console_tracker_type;
      logic [tcw_pkg::CELL_W-1:0]  cells [SCREEN_CELLS];
      int unsigned                 col;
      int unsigned                 row;
      logic [tcw_pkg::COLOR_W-1:0] back;
      logic [tcw_pkg::COLOR_W-1:0] fore;
      console_reply_type           expected_replies [$];
      int unsigned                 mismatches;
      int unsigned                 replies_seen;
      int unsigned                 scrolls;
      int unsigned                 mode_hits [8];

      function new();
         foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         col = 0;
         row = 0;
         back = tcw_pkg::RESET_BACKGROUND;
         fore = tcw_pkg::RESET_FOREGROUND;
         mismatches = 0;
         replies_seen = 0;
         scrolls = 0;
      endfunction

      function logic [7:0] attr();
         return {back, fore};
      endfunction

      function logic [tcw_pkg::CELL_W-1:0] blank();
         return {attr(), tcw_pkg::BLANK_CHAR};
      endfunction

      function void set_color(logic [tcw_pkg::CSR_INDEX_W-1:0] idx,
                              logic [tcw_pkg::COLOR_W-1:0] val);
         if (idx == tcw_pkg::CSR_BACKGROUND) back = val;
         else if (idx == tcw_pkg::CSR_FOREGROUND) fore = val;
      endfunction

      function void scroll_screen();
         for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
         for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) cells[i] = blank();
         scrolls++;
      endfunction

      function void put_glyph(logic [tcw_pkg::CHAR_W-1:0] c);
         if (c == tcw_pkg::NEWLINE_CHAR) begin
            col = 0;
            row++;
         end else begin
            cells[row * SCREEN_COLS + col] = {attr(), c};
            col++;
            if (col >= SCREEN_COLS) begin
               col = 0;
               row++;
            end
         end
         if (row >= SCREEN_ROWS) begin
            scroll_screen();
            row = SCREEN_ROWS - 1;
         end
      endfunction

      function void take_command(logic [tcw_pkg::MODE_W-1:0] mode,
                                 logic [tcw_pkg::CHAR_W-1:0] ch,
                                 logic [tcw_pkg::ADDR_W-1:0] addr);
         logic [tcw_pkg::CELL_W-1:0] rdata;
         logic [3:0]                 d;
         rdata = '0;
         d = ch[3:0];
         mode_hits[mode]++;
         case (mode)
            tcw_pkg::MODE_PUT: put_glyph(ch);
            tcw_pkg::MODE_HEX: begin
               if (d < 10) put_glyph(DIGIT_ZERO + {4'h0, d});
               else put_glyph(LETTER_A + {4'h0, d} - 8'd10);
            end
            tcw_pkg::MODE_BACKSPACE: begin
               if (col > 0) begin
                  col--;
               end else if (row > 0) begin
                  row--;
                  col = SCREEN_COLS - 1;
               end
               cells[row * SCREEN_COLS + col] = blank();
            end
            tcw_pkg::MODE_CLEAR: begin
               foreach (cells[i]) cells[i] = blank();
               col = 0;
               row = 0;
            end
            tcw_pkg::MODE_RECOLOR: begin
               foreach (cells[i]) cells[i] = {attr(), cells[i][7:0]};
            end
            tcw_pkg::MODE_READ: begin
               if (addr < SCREEN_CELLS) rdata = cells[addr];
            end
            default: ;
         endcase
         expected_replies.push_back('{cursor_pos: tcw_pkg::POS_W'(row * SCREEN_COLS + col),
                                      read_data: rdata});
      endfunction

      function void match_reply(logic [tcw_pkg::POS_W-1:0] pos,
                                logic [tcw_pkg::CELL_W-1:0] data);
         console_reply_type want;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            $error("reply with no command pending: cursor_pos %0d read_data 0x%04h", pos, data);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         if (pos !== want.cursor_pos) begin
            $error("cursor_pos expected %0d actual %0d", want.cursor_pos, pos);
            mismatches++;
         end
         if (data !== want.read_data) begin
            $error("read_data expected 0x%04h actual 0x%04h", want.read_data, data);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [tcw_pkg::MODE_W-1:0]      req_mode;
   logic [tcw_pkg::CHAR_W-1:0]      req_char_code;
   logic [tcw_pkg::ADDR_W-1:0]      req_read_address;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [tcw_pkg::POS_W-1:0]       rsp_cursor_pos;
   logic [tcw_pkg::CELL_W-1:0]      rsp_read_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tcw_pkg::COLOR_W-1:0]     csr_wdata;

   console_tracker_type tracker = new();
   int unsigned         quiet_cycles = 0;
   int unsigned         color_writes = 0;
   bit                  hold_off_req = 1'b0;

   text_console_writer_core #(
      .COLUMNS(SCREEN_COLS),
      .ROWS   (SCREEN_ROWS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_char_code   (req_char_code),
      .req_read_address(req_read_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_read_data   (rsp_read_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_reply(rsp_cursor_pos, rsp_read_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: stall pattern in segments, plus one long hold-off on request
   initial begin
      int style;
      int span;
      int phase_tick;
      rsp_stall = 1'b0;
      phase_tick = 0;
      forever begin
         style = $urandom_range(0, 3);
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(negedge clock);
            phase_tick++;
            if (hold_off_req) begin
               hold_off_req = 1'b0;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
            end else begin
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ((phase_tick % 5) < 2);
               endcase
            end
         end
      end
   end

   task automatic send_command(input logic [tcw_pkg::MODE_W-1:0] mode,
                               input logic [tcw_pkg::CHAR_W-1:0] ch,
                               input logic [tcw_pkg::ADDR_W-1:0] addr);
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_char_code <= ch;
      req_read_address <= addr;
      do @(posedge clock); while (req_stall);
      tracker.take_command(mode, ch, addr);
   endtask

   task automatic hold_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_color(input logic [tcw_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [tcw_pkg::COLOR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_color(idx, val);
      color_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_command(input bit scroll_heavy,
                                 output logic [tcw_pkg::MODE_W-1:0] mode,
                                 output logic [tcw_pkg::CHAR_W-1:0] ch,
                                 output logic [tcw_pkg::ADDR_W-1:0] addr);
      int r;
      r = $urandom_range(0, 999);
      ch = tcw_pkg::CHAR_W'($urandom);
      addr = tcw_pkg::ADDR_W'($urandom);
      mode = tcw_pkg::MODE_PUT;
      if (scroll_heavy && $urandom_range(0, 2) == 0) begin
         ch = tcw_pkg::NEWLINE_CHAR;
      end else if (r < 520) begin
         mode = tcw_pkg::MODE_PUT;
      end else if (r < 580) begin
         ch = tcw_pkg::NEWLINE_CHAR;
      end else if (r < 680) begin
         mode = tcw_pkg::MODE_HEX;
      end else if (r < 770) begin
         mode = tcw_pkg::MODE_BACKSPACE;
      end else if (r < 960) begin
         mode = tcw_pkg::MODE_READ;
         if ($urandom_range(0, 7) == 0) begin
            addr = tcw_pkg::ADDR_W'($urandom_range(SCREEN_CELLS, 2047));
         end else begin
            addr = tcw_pkg::ADDR_W'($urandom_range(0, SCREEN_CELLS - 1));
         end
      end else if (r < 963) begin
         mode = tcw_pkg::MODE_CLEAR;
      end else if (r < 970) begin
         mode = tcw_pkg::MODE_RECOLOR;
      end else begin
         mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end
   endtask

   task automatic run_phase(input int count, input bit scroll_heavy, input int solid_lead);
      int                         burst;
      int                         gap;
      logic [tcw_pkg::MODE_W-1:0] m;
      logic [tcw_pkg::CHAR_W-1:0] c;
      logic [tcw_pkg::ADDR_W-1:0] a;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         if (k >= solid_lead && burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            hold_sender(gap);
         end
         random_command(scroll_heavy, m, c, a);
         send_command(m, c, a);
         if (burst > 0) burst--;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = tcw_pkg::MODE_PUT;
      req_char_code = '0;
      req_read_address = '0;
      csr_valid = 1'b0;
      csr_index = tcw_pkg::CSR_BACKGROUND;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (req_stall);

      write_color(tcw_pkg::CSR_BACKGROUND, 4'h0);
      write_color(tcw_pkg::CSR_FOREGROUND, 4'hF);
      write_color(CSR_UNUSED_LO, 4'hA);
      write_color(CSR_UNUSED_HI, 4'h5);

      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_READ, 8'hFF, 11'd1999);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd2000);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'h7FF);
      send_command(tcw_pkg::MODE_BACKSPACE, 8'h00, 11'h7FF);
      send_command(tcw_pkg::MODE_PUT, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_PUT, 8'hFF, 11'h7FF);
      send_command(tcw_pkg::MODE_PUT, 8'h41, 11'd0);
      send_command(tcw_pkg::MODE_HEX, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_HEX, 8'h09, 11'd0);
      send_command(tcw_pkg::MODE_HEX, 8'h0A, 11'd0);
      send_command(tcw_pkg::MODE_HEX, 8'hF5, 11'd0);
      send_command(tcw_pkg::MODE_HEX, 8'h0F, 11'd0);
      send_command(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);
      send_command(tcw_pkg::MODE_BACKSPACE, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd79);
      send_command(MODE_SPARE_LO, 8'hFF, 11'h7FF);
      send_command(MODE_SPARE_HI, 8'h00, 11'd0);
      drain_replies();
      write_color(tcw_pkg::CSR_BACKGROUND, 4'hF);
      write_color(tcw_pkg::CSR_FOREGROUND, 4'h0);
      send_command(tcw_pkg::MODE_RECOLOR, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_CLEAR, 8'h00, 11'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd5);
      send_command(tcw_pkg::MODE_READ, 8'h00, 11'd1999);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_replies();
         case (p)
            0: begin
               write_color(tcw_pkg::CSR_BACKGROUND, 4'h0);
               write_color(tcw_pkg::CSR_FOREGROUND, 4'hF);
            end
            1: begin
               write_color(tcw_pkg::CSR_BACKGROUND, 4'hF);
               write_color(tcw_pkg::CSR_FOREGROUND, 4'hF);
            end
            2: begin
               write_color(tcw_pkg::CSR_BACKGROUND, 4'h0);
               write_color(tcw_pkg::CSR_FOREGROUND, 4'h0);
            end
            default: begin
               write_color(tcw_pkg::CSR_BACKGROUND, tcw_pkg::COLOR_W'($urandom));
               write_color(tcw_pkg::CSR_FOREGROUND, tcw_pkg::COLOR_W'($urandom));
            end
         endcase
         if (p % 3 == 1) begin
            write_color($urandom_range(0, 1) ? CSR_UNUSED_HI : CSR_UNUSED_LO,
                        tcw_pkg::COLOR_W'($urandom));
         end
         if (p == 3) hold_off_req = 1'b1;
         run_phase(PHASE_ITEMS, (p == 2 || p == 5), (p == 3) ? 40 : 0);
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d replies never arrived", tracker.pending());
         tracker.mismatches++;
      end
      $display("Commands: put %0d, hex %0d, backspace %0d, clear %0d, recolor %0d,",
               tracker.mode_hits[tcw_pkg::MODE_PUT], tracker.mode_hits[tcw_pkg::MODE_HEX],
               tracker.mode_hits[tcw_pkg::MODE_BACKSPACE],
               tracker.mode_hits[tcw_pkg::MODE_CLEAR],
               tracker.mode_hits[tcw_pkg::MODE_RECOLOR]);
      $display("  read %0d, unused %0d; screen scrolled %0d times, %0d color writes, %0d replies",
               tracker.mode_hits[tcw_pkg::MODE_READ],
               tracker.mode_hits[MODE_SPARE_LO] + tracker.mode_hits[MODE_SPARE_HI],
               tracker.scrolls, color_writes, tracker.replies_seen);
      if (tracker.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
